// ===== sv/ftsds_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the force/torque deadband smoother.
// No dependencies; imported by every module of the block.
package ftsds_pkg;

    // Default datapath sizes
    localparam int SAMPLE_WIDTH_DEF         = 24;
    localparam int WEIGHT_FRACTION_BITS_DEF = 16;

    // Channel layout after the remap: three force channels, then three torque channels
    localparam int N_CHAN  = 6;
    localparam int N_FORCE = 3;
    localparam int CH_FZ   = 2;
    localparam int CH_TZ   = 5;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_FORCE_DB  = 2'd0;
    localparam logic [1:0] REG_TORQUE_DB = 2'd1;
    localparam logic [1:0] REG_WEIGHT    = 2'd2;

    // Deadband reset values in Q12.12: 1.0 for force, 0.3 for torque
    localparam int FORCE_DB_RESET  = 4096;
    localparam int TORQUE_DB_RESET = 1229;

    // Acquisition status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FAIL = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } t_stage_ctl;

endpackage

// ===== sv/ftsds_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers: deadbands and smoothing weight.
// Depends on ftsds_pkg.
module ftsds_cfg_regs
    import ftsds_pkg::*;
#(
    parameter int SAMPLE_WIDTH         = SAMPLE_WIDTH_DEF,
    parameter int WEIGHT_FRACTION_BITS = WEIGHT_FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    output logic [SAMPLE_WIDTH-2:0]       o_force_db,
    output logic [SAMPLE_WIDTH-2:0]       o_torque_db,
    output logic [WEIGHT_FRACTION_BITS:0] o_weight
);

    localparam int DB_W = SAMPLE_WIDTH - 1;
    localparam int WT_W = WEIGHT_FRACTION_BITS + 1;
    localparam logic [WT_W-1:0] WT_ONE   = WT_W'(1) << WEIGHT_FRACTION_BITS;
    localparam logic [WT_W-1:0] WT_RESET = WT_W'(1) << (WEIGHT_FRACTION_BITS - 1);

    logic [DB_W-1:0] r_force_db;
    logic [DB_W-1:0] r_torque_db;
    logic [WT_W-1:0] r_weight;
    logic [1:0]      w_idx;
    logic            w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_db  <= DB_W'(FORCE_DB_RESET);
            r_torque_db <= DB_W'(TORQUE_DB_RESET);
            r_weight    <= WT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FORCE_DB:  r_force_db  <= pwdata[DB_W-1:0];
                REG_TORQUE_DB: r_torque_db <= pwdata[DB_W-1:0];
                REG_WEIGHT:    r_weight    <= pwdata[WT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FORCE_DB:  prdata = APB_DATA_W'(r_force_db);
            REG_TORQUE_DB: prdata = APB_DATA_W'(r_torque_db);
            REG_WEIGHT:    prdata = APB_DATA_W'(r_weight);
            default:       prdata = '0;
        endcase
    end

    // Clamp a weight above one to exactly one
    assign o_weight    = (r_weight > WT_ONE) ? WT_ONE : r_weight;
    assign o_force_db  = r_force_db;
    assign o_torque_db = r_torque_db;

endmodule

// ===== sv/ftsds_condition.sv =====
`timescale 1ns / 1ps
// One channel of input conditioning: optional saturating negation, then deadband.
// Depends on ftsds_pkg.
module ftsds_condition
    import ftsds_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_negate,
    input  logic        [SAMPLE_WIDTH-2:0] i_band,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample
);

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    logic signed [SAMPLE_WIDTH-1:0] w_cur;
    logic        [SAMPLE_WIDTH-1:0] w_mag;

    always_comb begin
        if (!i_negate) begin
            w_cur = i_sample;
        end else if (i_sample == S_MIN) begin
            w_cur = S_MAX;
        end else begin
            w_cur = -i_sample;
        end
    end

    // Unsigned magnitude; the most negative value maps to 2^(W-1) correctly
    assign w_mag    = w_cur[SAMPLE_WIDTH-1] ? (~w_cur + 1'b1) : w_cur;
    assign o_sample = (w_mag < {1'b0, i_band}) ? '0 : w_cur;

endmodule

// ===== sv/ftsds_ema_lane.sv =====
`timescale 1ns / 1ps
// One channel of the moving average, holding that channel's previous output.
// Depends on ftsds_pkg.
module ftsds_ema_lane
    import ftsds_pkg::*;
#(
    parameter int SAMPLE_WIDTH         = SAMPLE_WIDTH_DEF,
    parameter int WEIGHT_FRACTION_BITS = WEIGHT_FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [WEIGHT_FRACTION_BITS:0]  i_weight,
    output logic signed [SAMPLE_WIDTH-1:0] o_prev
);

    localparam int PW = WEIGHT_FRACTION_BITS + 2 + SAMPLE_WIDTH + 1;

    logic signed [SAMPLE_WIDTH-1:0] r_prev;
    logic signed [SAMPLE_WIDTH-1:0] n_prev;
    logic signed [SAMPLE_WIDTH:0]   w_diff;
    logic signed [PW-1:0]           w_prod;
    logic signed [PW-1:0]           w_step;

    // w*c + (1-w)*p = p + w*(c-p); the floor divides only the product term
    assign w_diff = $signed({i_sample[SAMPLE_WIDTH-1], i_sample})
                  - $signed({r_prev[SAMPLE_WIDTH-1], r_prev});
    assign w_prod = $signed({1'b0, i_weight}) * w_diff;
    assign w_step = w_prod >>> WEIGHT_FRACTION_BITS;
    assign n_prev = r_prev + w_step[SAMPLE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_en) begin
            r_prev <= n_prev;
        end
    end

    assign o_prev = r_prev;

endmodule

// ===== sv/ft_sensor_deadband_smoother_core.sv =====
`timescale 1ns / 1ps
// Force/torque smoother: an input beat passes the input register, then the result register,
// to the output beat; throughput one beat per cycle while the output side does not stall,
// bounded by the six multiply-add lanes feeding back on themselves.
// Synchronous active-low reset clears the pipeline valids, the previous outputs,
// the saturation flag and loads the register defaults. Depends on ftsds_pkg.
module ft_sensor_deadband_smoother_core
    import ftsds_pkg::*;
#(
    parameter int SAMPLE_WIDTH         = SAMPLE_WIDTH_DEF,
    parameter int WEIGHT_FRACTION_BITS = WEIGHT_FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_ADDR_W-1:0]          paddr,
    input  logic [APB_DATA_W-1:0]          pwdata,
    output logic [APB_DATA_W-1:0]          prdata,
    output logic                           pready,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_raw_fx,
    input  logic signed [SAMPLE_WIDTH-1:0] i_raw_fy,
    input  logic signed [SAMPLE_WIDTH-1:0] i_raw_fz,
    input  logic signed [SAMPLE_WIDTH-1:0] i_raw_tx,
    input  logic signed [SAMPLE_WIDTH-1:0] i_raw_ty,
    input  logic signed [SAMPLE_WIDTH-1:0] i_raw_tz,
    input  logic [1:0]                     i_read_status,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_fx,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_fy,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_fz,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_tx,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_ty,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_tz,
    output logic                           o_saturated,
    output logic                           o_read_error
);

    localparam int WT_W = WEIGHT_FRACTION_BITS + 1;
    localparam logic [WT_W-1:0] WT_ONE = WT_W'(1) << WEIGHT_FRACTION_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SAMPLE_WIDTH-2:0] w_force_db;
    logic [SAMPLE_WIDTH-2:0] w_torque_db;
    logic [WT_W-1:0]         w_weight;

    ftsds_cfg_regs #(
        .SAMPLE_WIDTH         (SAMPLE_WIDTH),
        .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_force_db  (w_force_db),
        .o_torque_db (w_torque_db),
        .o_weight    (w_weight)
    );

    // ------------------------------------------------------------------
    // Remap: swap x and y, negate z, for force and torque alike
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] w_map  [N_CHAN];
    logic signed [SAMPLE_WIDTH-1:0] w_cond [N_CHAN];

    assign w_map[0] = i_raw_fy;
    assign w_map[1] = i_raw_fx;
    assign w_map[2] = i_raw_fz;
    assign w_map[3] = i_raw_ty;
    assign w_map[4] = i_raw_tx;
    assign w_map[5] = i_raw_tz;

    // Negate the z channels, then apply the force or torque deadband
    for (genvar g = 0; g < N_CHAN; g++) begin : g_cond
        ftsds_condition #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cond (
            .i_sample (w_map[g]),
            .i_negate ((g == CH_FZ) || (g == CH_TZ)),
            .i_band   ((g < N_FORCE) ? w_force_db : w_torque_db),
            .o_sample (w_cond[g])
        );
    end

    // ------------------------------------------------------------------
    // Input register: holds the conditioned beat
    // ------------------------------------------------------------------
    t_stage_ctl                     r_s1;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_chan [N_CHAN];
    logic                           r_out_valid;
    logic                           r_sat;
    logic                           r_rd_err;
    logic                           n_sat;
    logic                           w_adv;
    logic                           w_take;

    // Advance into the result register whenever it is empty or being drained
    assign w_adv      = r_s1.valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_s1.valid | w_adv;
    assign w_take     = i_in_valid & o_in_ready;

    // Only the valid bit is reset; the payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1.valid <= i_in_valid;
        end
        if (w_take) begin
            r_s1.status <= i_read_status;
            r_s1_chan   <= w_cond;
        end
    end

    // ------------------------------------------------------------------
    // Moving-average lanes; each lane's state is also its output register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] w_prev [N_CHAN];

    for (genvar g = 0; g < N_CHAN; g++) begin : g_lane
        ftsds_ema_lane #(
            .SAMPLE_WIDTH         (SAMPLE_WIDTH),
            .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_adv),
            .i_sample (r_s1_chan[g]),
            .i_weight (w_weight),
            .o_prev   (w_prev[g])
        );
    end

    // ------------------------------------------------------------------
    // Status: set on saturation, hold on read failure, clear otherwise
    // ------------------------------------------------------------------
    always_comb begin
        priority if (r_s1.status == STATUS_SAT) begin
            n_sat = 1'b1;
        end else if (r_s1.status == STATUS_FAIL) begin
            n_sat = r_sat;
        end else begin
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sat       <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_sat       <= n_sat;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd_err <= (r_s1.status == STATUS_FAIL);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_fx     = w_prev[0];
    assign o_out_fy     = w_prev[1];
    assign o_out_fz     = w_prev[2];
    assign o_out_tx     = w_prev[3];
    assign o_out_ty     = w_prev[4];
    assign o_out_tz     = w_prev[5];
    assign o_saturated  = r_sat;
    assign o_read_error = r_rd_err;

`ifndef SYNTHESIS
    // A stalled result is never overwritten by the next beat
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_adv)
        else $error("result register overwritten while stalled");

    // A failed read leaves the saturation flag as it was
    a_fail_holds_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_s1.status == STATUS_FAIL)) |=> (r_sat == $past(r_sat)))
        else $error("saturation flag changed on read failure");

    // A saturated read sets the flag
    a_sat_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_s1.status == STATUS_SAT)) |=> o_saturated)
        else $error("saturation flag not set");

    // The effective weight never exceeds one
    a_weight_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_weight <= WT_ONE)
        else $error("smoothing weight above one");
`endif

endmodule

// ===== tb/tb_ft_sensor_deadband_smoother_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ft_sensor_deadband_smoother_core: a directed table, then random records
// under changing register settings and handshake pressure, scored against an in-bench smoother.
// Depends on ftsds_pkg and the core RTL only.
module tb_ft_sensor_deadband_smoother_core
    import ftsds_pkg::*;
();

    localparam int     SW          = SAMPLE_WIDTH_DEF;
    localparam int     WFB         = WEIGHT_FRACTION_BITS_DEF;
    localparam longint WEIGHT_ONE  = longint'(1) << WFB;
    localparam longint DB_MASK     = (longint'(1) << (SW - 1)) - 1;
    localparam longint WEIGHT_MASK = (longint'(1) << (WFB + 1)) - 1;
    localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    // Status code the package leaves unnamed; the core treats it like a good read
    localparam logic [1:0] STATUS_RSVD = 2'd3;
    // Register slot past the end of the map; writes there must be dropped
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    localparam int STALL_LIMIT  = 2000;  // cycles without any beat or register access before giving up
    localparam int DRAIN_LIMIT  = 500;
    localparam int SHOW_LIMIT   = 10;
    localparam int N_BLOCKS     = 8;
    localparam int BLOCK_BEATS  = 110;
    localparam int N_DIRECTED   = 29;

    typedef struct packed {
        logic [SW-1:0] fx, fy, fz, tx, ty, tz;
        logic [1:0]    status;
    } t_record;

    typedef struct packed {
        logic [SW-1:0] fx, fy, fz, tx, ty, tz;
        logic          saturated;
        logic          read_error;
    } t_smoothed;

    typedef enum logic [1:0] {ROW_BEAT, ROW_TYPED, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        logic [1:0] reg_idx;
        logic [31:0] wdata;
        t_record rec;
        t_smoothed want;
    } t_row;

    // Directed table. ROW_TYPED rows carry a hand-derived result; ROW_BEAT rows are scored
    // by the predictor; ROW_WRITE rows update a register once the pipe has drained.
    localparam t_row DIRECTED [N_DIRECTED] = '{
        // out of reset: zero in, zero out, flags clear
        '{ROW_TYPED, REG_UNUSED, 32'h0, '0, '0},
        // half-weight blend of full-scale values, including the negation clip
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{SMAX, SMIN, SMIN, SMIN, SMAX, SMAX, STATUS_OK}, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{24'd12345, -24'sd9876, 24'd4096, 24'd1000, -24'sd2000,
                                         -24'sd1229, STATUS_FAIL}, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{24'd12345, -24'sd9876, 24'd4096, 24'd1000, -24'sd2000,
                                         -24'sd1229, STATUS_SAT}, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{-24'sd777, 24'd5000, -24'sd4095, 24'd1228, 24'd1229,
                                         24'd3, STATUS_RSVD}, '0},
        // weight above one clamps to one: samples pass straight through
        '{ROW_WRITE, REG_WEIGHT, 32'h0001_FFFF, '0, '0},
        '{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, '0, '0},
        // one LSB either side of both default deadbands
        '{ROW_TYPED, REG_UNUSED, 32'h0, '{24'd4096, 24'd4095, -24'sd4096, 24'd1229, -24'sd1228,
                                          24'd1228, STATUS_OK},
          '{24'd0, 24'd4096, 24'd4096, 24'd0, 24'd1229, 24'd0, 1'b0, 1'b0}},
        // full scale with the swap and the clipped negation, sensor saturated
        '{ROW_TYPED, REG_UNUSED, 32'h0, '{SMAX, SMIN, SMIN, SMIN, SMAX, SMAX, STATUS_SAT},
          '{SMIN, SMAX, SMAX, SMAX, SMIN, 24'h800001, 1'b1, 1'b0}},
        // failed read: still smoothed, saturation flag held
        '{ROW_TYPED, REG_UNUSED, 32'h0, '{24'd0, 24'd0, SMAX, 24'd0, 24'd0, 24'd0, STATUS_FAIL},
          '{24'd0, 24'd0, 24'h800001, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1}},
        // reserved status clears the flag like a good read
        '{ROW_TYPED, REG_UNUSED, 32'h0, '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, STATUS_RSVD},
          '0},
        '{ROW_TYPED, REG_UNUSED, 32'h0, '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, STATUS_FAIL},
          '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1}},
        '{ROW_TYPED, REG_UNUSED, 32'h0, '{24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, STATUS_SAT},
          '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b0}},
        // oversized deadband keeps only its low bits; zero torque band passes everything
        '{ROW_WRITE, REG_FORCE_DB, 32'hFFFF_FFFF, '0, '0},
        '{ROW_WRITE, REG_TORQUE_DB, 32'h0, '0, '0},
        '{ROW_TYPED, REG_UNUSED, 32'h0, '{24'h7FFFFE, SMAX, SMIN, 24'd1, -24'sd1, 24'd0, STATUS_OK},
          '{SMAX, 24'd0, SMAX, -24'sd1, 24'd1, 24'd0, 1'b0, 1'b0}},
        // zero weight holds the previous output
        '{ROW_WRITE, REG_WEIGHT, 32'h0, '0, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{24'd300000, -24'sd300000, 24'd123, SMIN, SMAX,
                                         -24'sd5, STATUS_OK}, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{SMIN, SMAX, SMAX, 24'd42, 24'd0, SMIN, STATUS_FAIL}, '0},
        // smallest and largest non-trivial weights exercise floor rounding both ways
        '{ROW_WRITE, REG_WEIGHT, 32'd1, '0, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{SMAX, SMAX, SMIN, SMAX, SMIN, SMIN, STATUS_SAT}, '0},
        '{ROW_WRITE, REG_WEIGHT, 32'd65535, '0, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{SMIN, SMIN, SMAX, SMIN, SMAX, SMAX, STATUS_OK}, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{-24'sd8191, 24'd8191, -24'sd2, 24'd77, -24'sd77,
                                         24'd6000, STATUS_RSVD}, '0},
        // opposite extremes of the deadbands
        '{ROW_WRITE, REG_FORCE_DB, 32'h0, '0, '0},
        '{ROW_WRITE, REG_TORQUE_DB, 32'h007F_FFFF, '0, '0},
        '{ROW_WRITE, REG_WEIGHT, 32'h0000_8000, '0, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{24'd1, -24'sd1, 24'd0, SMIN, SMAX, SMIN, STATUS_OK}, '0},
        '{ROW_BEAT, REG_UNUSED, 32'h0, '{24'd65536, -24'sd65536, 24'd2, 24'h7FFFFE, -24'sd7,
                                         SMAX, STATUS_SAT}, '0}
    };

    // DUT inputs, all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic                  i_in_valid    = 1'b0;
    logic [SW-1:0]         i_raw_fx      = '0;
    logic [SW-1:0]         i_raw_fy      = '0;
    logic [SW-1:0]         i_raw_fz      = '0;
    logic [SW-1:0]         i_raw_tx      = '0;
    logic [SW-1:0]         i_raw_ty      = '0;
    logic [SW-1:0]         i_raw_tz      = '0;
    logic [1:0]            i_read_status = STATUS_OK;
    logic                  i_out_ready   = 1'b0;

    // DUT outputs
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [SW-1:0]         o_out_fx, o_out_fy, o_out_fz, o_out_tx, o_out_ty, o_out_tz;
    logic                  o_saturated;
    logic                  o_read_error;

    // Predictor state: register shadows, per-channel previous outputs, saturation flag
    longint force_db_cfg;
    longint torque_db_cfg;
    longint weight_cfg;
    longint ema_prev [N_CHAN];
    logic   sat_state;

    t_smoothed smoothed_due [$];  // results owed by the core, oldest first

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatches     = 0;
    int          beats_sent     = 0;
    int          results_seen   = 0;
    int          writes_done    = 0;
    int          quiet_cycles   = 0;

    ft_sensor_deadband_smoother_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_raw_fx      (i_raw_fx),
        .i_raw_fy      (i_raw_fy),
        .i_raw_fz      (i_raw_fz),
        .i_raw_tx      (i_raw_tx),
        .i_raw_ty      (i_raw_ty),
        .i_raw_tz      (i_raw_tz),
        .i_read_status (i_read_status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_fx      (o_out_fx),
        .o_out_fy      (o_out_fy),
        .o_out_fz      (o_out_fz),
        .o_out_tx      (o_out_tx),
        .o_out_ty      (o_out_ty),
        .o_out_tz      (o_out_tz),
        .o_saturated   (o_saturated),
        .o_read_error  (o_read_error)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint sx(logic [SW-1:0] v);
        return longint'($signed(v));
    endfunction

    // Negate, clipping the most negative code to the most positive one
    function automatic longint neg_clip(longint x);
        return (x == sx(SMIN)) ? sx(SMAX) : -x;
    endfunction

    // Advance the smoother by one record and return the result it owes
    function automatic t_smoothed smooth_record(t_record r);
        longint        lane [N_CHAN];
        logic [SW-1:0] res  [N_CHAN];
        longint        w, band, mag, kept, acc;
        w = (weight_cfg > WEIGHT_ONE) ? WEIGHT_ONE : weight_cfg;
        // remap: swap x and y, negate z, for force and torque alike
        lane[0]      = sx(r.fy);
        lane[1]      = sx(r.fx);
        lane[CH_FZ]  = neg_clip(sx(r.fz));
        lane[3]      = sx(r.ty);
        lane[4]      = sx(r.tx);
        lane[CH_TZ]  = neg_clip(sx(r.tz));
        for (int i = 0; i < N_CHAN; i++) begin
            band = (i < N_FORCE) ? force_db_cfg : torque_db_cfg;
            mag  = (lane[i] < 0) ? -lane[i] : lane[i];
            kept = (mag < band) ? 0 : lane[i];
            acc  = w * kept + (WEIGHT_ONE - w) * ema_prev[i];
            // arithmetic shift floors toward minus infinity
            ema_prev[i] = acc >>> WFB;
            res[i] = ema_prev[i][SW-1:0];
        end
        // a failed read leaves the flag alone; anything else sets or clears it
        if (r.status == STATUS_SAT) begin
            sat_state = 1'b1;
        end else if (r.status != STATUS_FAIL) begin
            sat_state = 1'b0;
        end
        return '{res[0], res[1], res[2], res[3], res[4], res[5], sat_state,
                 r.status == STATUS_FAIL};
    endfunction

    function automatic string fmt(t_smoothed s);
        return $sformatf("f=(%0d %0d %0d) t=(%0d %0d %0d) sat=%b err=%b",
                         $signed(s.fx), $signed(s.fy), $signed(s.fz),
                         $signed(s.tx), $signed(s.ty), $signed(s.tz),
                         s.saturated, s.read_error);
    endfunction

    task automatic log_mismatch(string why, string want_txt, t_smoothed got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
            $display("[%0t] %s\n  expected %s\n  actual   %s", $time, why, want_txt, fmt(got));
        end
    endtask

    // Two-phase register write; update the shadow once the access beat lands
    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FORCE_DB:  force_db_cfg  = longint'(data) & DB_MASK;
            REG_TORQUE_DB: torque_db_cfg = longint'(data) & DB_MASK;
            REG_WEIGHT:    weight_cfg    = longint'(data) & WEIGHT_MASK;
            default: ;
        endcase
        writes_done++;
    endtask

    // Hold the input side quiet until every owed result is out, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (smoothed_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Present one record and hold it until accepted; queue what it should produce
    task automatic send_record(t_record r, logic typed, t_smoothed want);
        t_smoothed predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_raw_fx      <= r.fx;
        i_raw_fy      <= r.fy;
        i_raw_fz      <= r.fz;
        i_raw_tx      <= r.tx;
        i_raw_ty      <= r.ty;
        i_raw_tz      <= r.tz;
        i_read_status <= r.status;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        // the predictor advances on every accepted beat, typed rows included
        predicted = smooth_record(r);
        smoothed_due.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // Samples biased toward full scale, the active deadband edge and small values
    function automatic logic [SW-1:0] rand_sample(longint band);
        longint v;
        case ($urandom_range(0, 7))
            0:       v = sx(SMAX);
            1:       v = sx(SMIN);
            2, 3:    v = longint'($urandom);
            4:       v = band + longint'($urandom_range(0, 2)) - 1;
            5:       v = longint'($urandom_range(0, 64));
            default: v = longint'($urandom_range(0, int'(band)));
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v[SW-1:0];
    endfunction

    function automatic t_record rand_record(t_record prev_rec);
        t_record r;
        // repeat the last record now and then so the average can settle
        if ($urandom_range(0, 4) == 0) begin
            r = prev_rec;
        end else begin
            r.fx = rand_sample(force_db_cfg);
            r.fy = rand_sample(force_db_cfg);
            r.fz = rand_sample(force_db_cfg);
            r.tx = rand_sample(torque_db_cfg);
            r.ty = rand_sample(torque_db_cfg);
            r.tz = rand_sample(torque_db_cfg);
        end
        case ($urandom_range(0, 9))
            6:       r.status = STATUS_FAIL;
            7, 9:    r.status = STATUS_SAT;
            8:       r.status = STATUS_RSVD;
            default: r.status = STATUS_OK;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_band();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'h007F_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(0, 8192);
            default: return $urandom_range(0, 300000);
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd65535;
            3:       return 32'd65536;
            4:       return $urandom;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // Receiver: drop ready at random according to the current phase
    initial begin
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Scoreboard: compare every output beat with the oldest owed result
    always @(posedge i_clk) begin : score_results
        t_smoothed got;
        t_smoothed want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_fx, o_out_fy, o_out_fz, o_out_tx, o_out_ty, o_out_tz,
                    o_saturated, o_read_error};
            if (smoothed_due.size() == 0) begin
                log_mismatch("result beat with nothing owed", "nothing", got);
            end else begin
                want = smoothed_due.pop_front();
                if (got !== want) begin
                    log_mismatch("result beat differs", fmt(want), got);
                end
            end
            results_seen++;
        end
    end

    // Watchdog: a run that moves no beat and makes no register access for too long is hung
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ft_sensor_deadband_smoother_core verification failed");
            $finish;
        end
    end

    initial begin
        t_row    row;
        t_record rec;
        // shadows start at the core's reset values
        force_db_cfg  = FORCE_DB_RESET;
        torque_db_cfg = TORQUE_DB_RESET;
        weight_cfg    = WEIGHT_ONE >> 1;
        sat_state     = 1'b0;
        foreach (ema_prev[i]) ema_prev[i] = 0;
        rec = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, no idling
        for (int n = 0; n < N_DIRECTED; n++) begin
            row = DIRECTED[n];
            if (row.kind == ROW_WRITE) begin
                wait_drained();
                reg_write(row.reg_idx, row.wdata);
            end else begin
                send_record(row.rec, row.kind == ROW_TYPED, row.want);
            end
        end

        // Random blocks: fresh register settings per block, rotate through the idle phases
        for (int b = 0; b < N_BLOCKS; b++) begin
            wait_drained();
            reg_write(REG_FORCE_DB, rand_band());
            reg_write(REG_TORQUE_DB, rand_band());
            reg_write(REG_WEIGHT, rand_weight());
            if (b == 3) begin
                reg_write(REG_UNUSED, $urandom);
            end
            case (b % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (int k = 0; k < BLOCK_BEATS; k++) begin
                rec = rand_record(rec);
                send_record(rec, 1'b0, '0);
            end
        end

        // Drain: release back-pressure, wait for the tail, then let the pipe settle
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_in_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && smoothed_due.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (smoothed_due.size() != 0) begin
            mismatches += smoothed_due.size();
            $display("%0d owed results never came out", smoothed_due.size());
        end

        $display("Run covered %0d records and %0d result beats across %0d register writes,",
                 beats_sent, results_seen, writes_done);
        $display("with free-running, sender-idle, receiver-stall and mixed phases; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("ft_sensor_deadband_smoother_core verification clean");
        end else begin
            $display("ft_sensor_deadband_smoother_core verification failed");
        end
        $finish;
    end

endmodule
